@@ rtl/assert_macros.svh @@
// Assertion macros used by the memory core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ rtl/bbam_pkg.sv @@
// Types, constants and helper functions of the bitplane blit memory core
`default_nettype none
package bbam_pkg;

    localparam int unsigned RAM_DEPTH       = 8192;
    localparam int unsigned PALETTE_ENTRIES = 64;
    localparam int unsigned BANK_DEPTH      = RAM_DEPTH / 2;
    localparam int unsigned BANK_AW         = $clog2(BANK_DEPTH);
    localparam int unsigned ROW_W           = BANK_AW - 8;
    localparam int unsigned PAL_IDX_W       = $clog2(PALETTE_ENTRIES);

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic {
        RGN_VIDEO = 1'b0,
        RGN_COLOR = 1'b1
    } t_region;

    typedef enum logic {
        CFG_SHIFT_CTL = 1'b0,
        CFG_MODE_CTL  = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ALU_DS_XM       = 4'd0,
        ALU_OR_XM       = 4'd1,
        ALU_XM_AND_D0   = 4'd2,
        ALU_ZERO        = 4'd3,
        ALU_AND_XM      = 4'd4,
        ALU_D0_XM       = 4'd5,
        ALU_XOR         = 4'd6,
        ALU_DS_AND_D0XM = 4'd7,
        ALU_XM_OR_D0    = 4'd8,
        ALU_XOR_XM      = 4'd9,
        ALU_D0          = 4'd10,
        ALU_AND         = 4'd11,
        ALU_MASK        = 4'd12,
        ALU_DS_OR_D0XM  = 4'd13,
        ALU_OR          = 4'd14,
        ALU_DS          = 4'd15
    } t_alu_fn;

    typedef struct packed {
        t_op         op;
        t_region     region;
        logic [13:0] address;
        logic [7:0]  write_data;
    } t_req;

    typedef struct packed {
        logic [7:0]           read_data;
        logic                 palette_update;
        logic [PAL_IDX_W-1:0] pal_entry;
        logic [8:0]           palette_value;
    } t_rsp;

    typedef struct packed {
        t_cfg_reg   index;
        logic [7:0] value;
    } t_cfg;

    typedef struct packed {
        logic [4:0] color;
        logic [7:0] pixel;
    } t_mem_word;

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = v[i];
        end
        return r;
    endfunction

    function automatic logic [15:0] alu16(input t_alu_fn f, input logic [15:0] ds,
                                          input logic [15:0] d0, input logic [15:0] m);
        logic [15:0] r;
        unique case (f)
            ALU_DS_XM:       r = ds ^ m;
            ALU_OR_XM:       r = (ds | d0) ^ m;
            ALU_XM_AND_D0:   r = (ds ^ m) & d0;
            ALU_ZERO:        r = '0;
            ALU_AND_XM:      r = (ds & d0) ^ m;
            ALU_D0_XM:       r = d0 ^ m;
            ALU_XOR:         r = ds ^ d0;
            ALU_DS_AND_D0XM: r = ds & (d0 ^ m);
            ALU_XM_OR_D0:    r = (ds ^ m) | d0;
            ALU_XOR_XM:      r = (ds ^ d0) ^ m;
            ALU_D0:          r = d0;
            ALU_AND:         r = ds & d0;
            ALU_MASK:        r = m;
            ALU_DS_OR_D0XM:  r = ds | (d0 ^ m);
            ALU_OR:          r = ds | d0;
            ALU_DS:          r = ds;
            default:         r = ds;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/bbam_chan_if.sv @@
// Valid/ready channel carrying one payload word
`default_nettype none
interface bbam_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/bitplane_blit_alu_memory_core.sv @@
// Bitplane blit memory core: CPU accesses to the bitmap and color RAMs
//
// Channels: i_req takes one CPU bus access (op, region, address, write_data);
// o_rsp returns exactly one word per access (read data, palette update);
// i_cfg writes shift_control (index 0) or mode_control (index 1); it is always ready.
// Both RAMs live in two synchronous banks split by address bit 8, so the two
// bytes of a window (256 apart) always sit in different banks.
// Flow: an access is accepted and its banks are read into r_rd0/r_rd1;
// once the response register is free, the access is modified, written back
// and loaded into the response register. The next access is accepted only
// after the write-back, so reads never overlap a pending write to the same
// entry, and accesses never overlap in the bank ports.
// Reset: control state clears, then a clearing pass writes zero to every
// entry of both banks, during which i_req is not ready; configuration
// writes are taken throughout.
// Stall: the response register holds while o_rsp.ready is low; one further
// access may be accepted and waits in its read stage until the register frees.
`default_nettype none
`include "assert_macros.svh"
module bitplane_blit_alu_memory_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bbam_chan_if.sink   i_req,
    bbam_chan_if.source o_rsp,
    bbam_chan_if.sink   i_cfg
);
    import bbam_pkg::*;

    localparam logic [BANK_AW-1:0] CLR_LAST = BANK_AW'(BANK_DEPTH - 1);

    t_mem_word r_mem_b0 [BANK_DEPTH];
    t_mem_word r_mem_b1 [BANK_DEPTH];

    logic               r_clr;
    logic [BANK_AW-1:0] r_clr_idx;
    logic               r_busy;
    logic               r_rsp_valid;
    logic [7:0]         r_shift_ctl;
    logic [7:0]         r_mode_ctl;
    logic [4:0]         r_cur_color;
    t_req               r_req;
    logic [BANK_AW-1:0] r_idx0;
    logic [BANK_AW-1:0] r_idx1;
    t_mem_word          r_rd0;
    t_mem_word          r_rd1;
    t_rsp               r_rsp;

    logic               req_acc;
    logic               cfg_acc;
    logic               done;
    logic [ROW_W-1:0]   in_row;
    logic [BANK_AW-1:0] idx_same;
    logic [BANK_AW-1:0] idx_next;
    logic [BANK_AW-1:0] rd_idx0;
    logic [BANK_AW-1:0] rd_idx1;

    logic [2:0]  sh;
    logic        lr;
    logic        sel;
    logic [15:0] m;
    logic [7:0]  dm;
    logic [15:0] ds;
    logic [15:0] d0;
    logic [15:0] alu_out;
    logic [15:0] res;
    logic [7:0]  rd_masked;
    logic [15:0] rot;
    logic        prot;
    logic        tag;
    logic        pseudo;
    logic [4:0]  cl;
    logic [4:0]  cr;

    logic        w0_pix_en;
    logic        w1_pix_en;
    logic        w0_col_en;
    logic        w1_col_en;
    logic [4:0]  w0_col;
    logic [4:0]  w1_col;
    logic        cur_we;
    logic [4:0]  n_cur_color;
    t_rsp        n_rsp;

    logic               m0_pix_we;
    logic               m0_col_we;
    logic               m1_pix_we;
    logic               m1_col_we;
    logic [BANK_AW-1:0] m0_idx;
    logic [BANK_AW-1:0] m1_idx;
    t_mem_word          m0_word;
    t_mem_word          m1_word;

    assign i_req.ready = !r_busy && !r_clr;
    assign i_cfg.ready = 1'b1;
    assign req_acc     = i_req.valid && i_req.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign done        = r_busy && (!r_rsp_valid || o_rsp.ready);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    // bank 0 holds bit8 clear, bank 1 bit8 set; a video window at bit8 set wraps a row
    assign in_row   = i_req.data.address[12:9];
    assign idx_same = {in_row, i_req.data.address[7:0]};
    assign idx_next = {ROW_W'(in_row + 1'b1), i_req.data.address[7:0]};
    assign rd_idx0  = (i_req.data.address[8] && i_req.data.region == RGN_VIDEO)
                      ? idx_next : idx_same;
    assign rd_idx1  = idx_same;

    assign sel  = r_req.address[8];
    assign sh   = r_req.address[13] ? r_shift_ctl[3:1] : r_shift_ctl[7:5];
    assign lr   = r_req.address[13] ? r_shift_ctl[0] : r_shift_ctl[4];
    assign prot = (r_req.address[7:5] == 3'b000) && !r_mode_ctl[5];
    assign tag  = !r_req.address[13] && !r_mode_ctl[7];
    assign pseudo = (r_req.address[7:5] == 3'b000);

    always_comb begin
        m = 16'hFF00 >> sh;
        if (r_req.address[12:8] == 5'h1F) begin
            m = m & (r_mode_ctl[4] ? 16'h00FF : 16'hFF00);
        end
    end

    assign dm        = lr ? mirror8(r_req.write_data) : r_req.write_data;
    assign ds        = {dm, 8'h00} >> sh;
    assign d0        = sel ? {r_rd1.pixel, r_rd0.pixel} : {r_rd0.pixel, r_rd1.pixel};
    assign alu_out   = alu16(t_alu_fn'(~r_mode_ctl[3:0]), ds & m, d0 & m, m);
    assign res       = (d0 & ~m) | (alu_out & m);
    assign rd_masked = (d0[15:8] & m[15:8]) | (d0[7:0] & m[7:0]);
    assign rot       = {rd_masked, rd_masked} << sh;

    always_comb begin
        w0_pix_en   = 1'b0;
        w1_pix_en   = 1'b0;
        w0_col_en   = 1'b0;
        w1_col_en   = 1'b0;
        w0_col      = r_cur_color;
        w1_col      = r_cur_color;
        cur_we      = 1'b0;
        n_cur_color = r_cur_color;
        cl          = '0;
        cr          = '0;
        n_rsp       = '0;
        if (r_req.region == RGN_VIDEO) begin
            if (r_req.op == OP_WRITE) begin
                if (!prot) begin
                    w0_pix_en = 1'b1;
                    w1_pix_en = 1'b1;
                    if (tag) begin
                        w0_col_en = sel ? (|m[7:0]) : (|m[15:8]);
                        w1_col_en = sel ? (|m[15:8]) : (|m[7:0]);
                    end
                end
            end else begin
                n_rsp.read_data = rot[15:8];
            end
        end else if (pseudo) begin
            if (r_req.op == OP_WRITE) begin
                cl          = r_mode_ctl[7] ? r_cur_color : r_req.write_data[4:0];
                cr          = {(r_mode_ctl[7] ? r_cur_color[4] : r_req.write_data[4]),
                               r_req.address[8], r_req.write_data[7:5]};
                w0_col_en   = 1'b1;
                w1_col_en   = 1'b1;
                w0_col      = cl;
                w1_col      = cr;
                cur_we      = 1'b1;
                n_cur_color = cl;
            end else begin
                cl              = r_rd0.color;
                cr              = r_rd1.color;
                n_rsp.read_data = {cr[2:0], cl};
            end
            if (r_mode_ctl[6]) begin
                n_rsp.palette_update = 1'b1;
                n_rsp.pal_entry      = {r_req.address[9], r_req.address[4:0]};
                n_rsp.palette_value  = {cl[1:0], cr[3:0], cl[4:2]};
            end
        end else if (r_req.op == OP_WRITE) begin
            n_cur_color = r_mode_ctl[7] ? r_cur_color : r_req.write_data[4:0];
            cur_we      = 1'b1;
            w0_col      = n_cur_color;
            w1_col      = n_cur_color;
            w0_col_en   = !sel;
            w1_col_en   = sel;
        end else begin
            n_rsp.read_data = {3'b000, (sel ? r_rd1.color : r_rd0.color)};
        end
    end

    always_comb begin
        if (r_clr) begin
            m0_pix_we = 1'b1;
            m0_col_we = 1'b1;
            m1_pix_we = 1'b1;
            m1_col_we = 1'b1;
            m0_idx    = r_clr_idx;
            m1_idx    = r_clr_idx;
            m0_word   = '0;
            m1_word   = '0;
        end else begin
            m0_pix_we = done && w0_pix_en;
            m0_col_we = done && w0_col_en;
            m1_pix_we = done && w1_pix_en;
            m1_col_we = done && w1_col_en;
            m0_idx    = r_idx0;
            m1_idx    = r_idx1;
            m0_word   = '{color: w0_col, pixel: (sel ? res[7:0] : res[15:8])};
            m1_word   = '{color: w1_col, pixel: (sel ? res[15:8] : res[7:0])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (m0_pix_we) begin
            r_mem_b0[m0_idx].pixel <= m0_word.pixel;
        end
        if (m0_col_we) begin
            r_mem_b0[m0_idx].color <= m0_word.color;
        end
        if (req_acc) begin
            r_rd0 <= r_mem_b0[rd_idx0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m1_pix_we) begin
            r_mem_b1[m1_idx].pixel <= m1_word.pixel;
        end
        if (m1_col_we) begin
            r_mem_b1[m1_idx].color <= m1_word.color;
        end
        if (req_acc) begin
            r_rd1 <= r_mem_b1[rd_idx1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= 1'b1;
            r_clr_idx   <= '0;
            r_busy      <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_shift_ctl <= '0;
            r_mode_ctl  <= '0;
            r_cur_color <= '0;
        end else begin
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == CLR_LAST) begin
                    r_clr <= 1'b0;
                end
            end
            if (req_acc) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (done && cur_we) begin
                r_cur_color <= n_cur_color;
            end
            if (cfg_acc) begin
                unique case (i_cfg.data.index)
                    CFG_SHIFT_CTL: r_shift_ctl <= i_cfg.data.value;
                    CFG_MODE_CTL:  r_mode_ctl  <= i_cfg.data.value;
                    default:       r_mode_ctl  <= r_mode_ctl;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req  <= i_req.data;
            r_idx0 <= rd_idx0;
            r_idx1 <= rd_idx1;
        end
        if (done) begin
            r_rsp <= n_rsp;
        end
    end

    `ASSERT_ALWAYS(a_acc_sets_busy, i_clk, i_rst_n, req_acc |=> r_busy)
    `ASSERT_ALWAYS(a_done_loads_rsp, i_clk, i_rst_n, done |=> (!r_busy && r_rsp_valid))
    `ASSERT_ALWAYS(a_rsp_from_busy, i_clk, i_rst_n, $rose(r_rsp_valid) |-> $past(r_busy))
    `ASSERT_NEVER(a_idle_in_clear, i_clk, i_rst_n, r_clr && (r_busy || r_rsp_valid))

endmodule
`default_nettype wire

@@ test/tb_bitplane_blit_alu_memory_core.sv @@
// Self-checking testbench: CPU bitmap/color RAM accesses checked against a shadow RAM model
module tb_bitplane_blit_alu_memory_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bbam_pkg::*;

    localparam int          CLK_PERIOD        = 12;
    localparam int unsigned RUN_LIMIT_CYCLES  = 600000;
    localparam int unsigned DRAIN_PAD         = 4;
    localparam int unsigned PHASES            = 20;
    localparam int unsigned WORDS_PER_PHASE   = 62;
    localparam int unsigned LONG_HOLD         = 300;
    localparam int unsigned MAX_REPORTS       = 10;

    logic i_clk;
    logic i_rst_n;

    bbam_chan_if #(.T(t_req)) req_if ();
    bbam_chan_if #(.T(t_rsp)) rsp_if ();
    bbam_chan_if #(.T(t_cfg)) cfg_if ();

    bitplane_blit_alu_memory_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    logic [7:0]  bitmap_mem [RAM_DEPTH];
    logic [4:0]  color_mem  [RAM_DEPTH];
    logic [4:0]  pen_color;
    logic [7:0]  shift_reg;
    logic [7:0]  mode_reg;
    t_rsp        rsp_due [$];
    int unsigned fail_count      = 0;
    int unsigned idle_pct        = 0;
    int unsigned rsp_hold_cycles = 0;
    int unsigned rsp_stall_left  = 0;
    logic [13:0] hot_addr [12];

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic logic [15:0] window_mask(input logic [13:0] a, input logic [2:0] sh);
        logic [15:0] m;
        m = 16'hff00 >> sh;
        if (a[12:8] == 5'h1f) m &= mode_reg[4] ? 16'h00ff : 16'hff00;
        return m;
    endfunction

    function automatic t_rsp predict_access(input t_req r);
        t_rsp        w;
        logic [12:0] a1, a2, off;
        logic [2:0]  sh;
        logic        mir;
        logic [7:0]  dm, d8;
        logic [15:0] m, ds, d0, s, d, f_out, rot;
        logic [4:0]  cl, cr;
        w   = '0;
        a1  = r.address[12:0];
        a2  = a1 + 13'h100;
        off = r.address[12:0];
        sh  = r.address[13] ? shift_reg[3:1] : shift_reg[7:5];
        mir = r.address[13] ? shift_reg[0] : shift_reg[4];
        m   = window_mask(r.address, sh);
        if (r.region == RGN_VIDEO && r.op == OP_READ) begin
            d8  = (bitmap_mem[a1] & m[15:8]) | (bitmap_mem[a2] & m[7:0]);
            rot = {d8, d8} << sh;
            w.read_data = rot[15:8];
        end else if (r.region == RGN_VIDEO) begin
            if (r.address[7:5] != 3'b000 || mode_reg[5]) begin
                for (int i = 0; i < 8; i++) dm[i] = mir ? r.write_data[7-i] : r.write_data[i];
                ds = {dm, 8'h00} >> sh;
                s  = ds & m;
                d0 = {bitmap_mem[a1], bitmap_mem[a2]};
                d  = d0 & m;
                case (t_alu_fn'(~mode_reg[3:0]))
                    ALU_DS_XM:       f_out = s ^ m;
                    ALU_OR_XM:       f_out = (s | d) ^ m;
                    ALU_XM_AND_D0:   f_out = (s ^ m) & d;
                    ALU_ZERO:        f_out = '0;
                    ALU_AND_XM:      f_out = (s & d) ^ m;
                    ALU_D0_XM:       f_out = d ^ m;
                    ALU_XOR:         f_out = s ^ d;
                    ALU_DS_AND_D0XM: f_out = s & (d ^ m);
                    ALU_XM_OR_D0:    f_out = (s ^ m) | d;
                    ALU_XOR_XM:      f_out = (s ^ d) ^ m;
                    ALU_D0:          f_out = d;
                    ALU_AND:         f_out = s & d;
                    ALU_MASK:        f_out = m;
                    ALU_DS_OR_D0XM:  f_out = s | (d ^ m);
                    ALU_OR:          f_out = s | d;
                    default:         f_out = s;
                endcase
                d0 = (d0 & ~m) | (f_out & m);
                bitmap_mem[a1] = d0[15:8];
                bitmap_mem[a2] = d0[7:0];
                if (!r.address[13] && !mode_reg[7]) begin
                    if (m[15:8] != 8'h00) color_mem[a1] = pen_color;
                    if (m[7:0] != 8'h00) color_mem[a2] = pen_color;
                end
            end
        end else if (off[7:5] == 3'b000) begin
            if (r.op == OP_WRITE) begin
                cl = mode_reg[7] ? pen_color : r.write_data[4:0];
                cr = {mode_reg[7] ? pen_color[4] : r.write_data[4], off[8], r.write_data[7:5]};
                color_mem[{off[12:9], 1'b0, off[7:0]}] = cl;
                color_mem[{off[12:9], 1'b1, off[7:0]}] = cr;
                pen_color = cl;
            end else begin
                cl = color_mem[{off[12:9], 1'b0, off[7:0]}];
                cr = color_mem[{off[12:9], 1'b1, off[7:0]}];
                w.read_data = {cr[2:0], cl};
            end
            if (mode_reg[6]) begin
                w.palette_update = 1'b1;
                w.pal_entry      = {off[9], off[4:0]};
                w.palette_value  = {cl[1:0], cr[3:0], cl[4:2]};
            end
        end else if (r.op == OP_WRITE) begin
            cl = mode_reg[7] ? pen_color : r.write_data[4:0];
            color_mem[off] = cl;
            pen_color      = cl;
        end else begin
            w.read_data = {3'b000, color_mem[off]};
        end
        return w;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        t_rsp got, want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (rsp_due.size() == 0) begin
                    note_failure($sformatf("unexpected word: rd=%02h upd=%0b idx=%0d val=%03h",
                        got.read_data, got.palette_update, got.pal_entry,
                        got.palette_value));
                end else begin
                    want = rsp_due.pop_front();
                    if (got.read_data !== want.read_data
                            || got.palette_update !== want.palette_update
                            || got.pal_entry !== want.pal_entry
                            || got.palette_value !== want.palette_value) begin
                        note_failure($sformatf(
                            "mismatch: exp %02h %0b %0d %03h, got %02h %0b %0d %03h",
                            want.read_data, want.palette_update, want.pal_entry,
                            want.palette_value, got.read_data, got.palette_update,
                            got.pal_entry, got.palette_value));
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.data.index == CFG_SHIFT_CTL) shift_reg = cfg_if.data.value;
                else mode_reg = cfg_if.data.value;
            end
            if (req_if.valid && req_if.ready) rsp_due.push_back(predict_access(req_if.data));
        end
    end

    // response side: random stalls, or a long hold when asked
    always @(negedge i_clk) begin
        if (rsp_hold_cycles != 0) begin
            rsp_stall_left  = rsp_hold_cycles;
            rsp_hold_cycles = 0;
        end else if (rsp_stall_left == 0 && idle_pct != 0 && $urandom_range(0, 399) < idle_pct) begin
            rsp_stall_left = $urandom_range(1, 18);
        end
        if (rsp_stall_left != 0) begin
            rsp_if.ready = 1'b0;
            rsp_stall_left--;
        end else begin
            rsp_if.ready = 1'b1;
        end
    end

    task automatic send_access(input t_req r);
        @(negedge i_clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic cpu_access(input t_op op, input t_region rg, input logic [13:0] a,
                              input logic [7:0] wd);
        t_req r;
        r.op         = op;
        r.region     = rg;
        r.address    = a;
        r.write_data = wd;
        send_access(r);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [7:0] v);
        @(negedge i_clk);
        cfg_if.valid      = 1'b1;
        cfg_if.data.index = idx;
        cfg_if.data.value = v;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // drop valid and hold until every word is back
    task automatic wait_drain();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (rsp_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [7:0] shift_v, input logic [7:0] mode_v);
        wait_drain();
        write_reg(CFG_SHIFT_CTL, shift_v);
        write_reg(CFG_MODE_CTL, mode_v);
    endtask

    function automatic void make_hot_set();
        logic [4:0] base_row;
        logic [7:0] col_a, col_b;
        base_row = ($urandom_range(0, 2) == 0) ? 5'h1d : 5'($urandom);
        col_a    = 8'($urandom);
        col_b    = 8'($urandom);
        foreach (hot_addr[k]) begin
            hot_addr[k] = {1'($urandom), base_row + 5'($urandom_range(0, 3)),
                           (k % 2 == 0) ? col_a : col_b};
        end
    endfunction

    function automatic t_req rand_access();
        t_req        r;
        int unsigned pick;
        pick         = $urandom_range(0, 99);
        r.write_data = 8'($urandom);
        r.address    = hot_addr[$urandom_range(0, 11)];
        if (pick < 35) begin
            r.op     = OP_WRITE;
            r.region = RGN_VIDEO;
        end else if (pick < 60) begin
            r.op     = OP_READ;
            r.region = RGN_VIDEO;
        end else if (pick < 88) begin
            r.op     = t_op'($urandom_range(0, 1));
            r.region = RGN_COLOR;
            if (pick < 76) begin
                r.address = 14'($urandom) & 14'h3f1f;
                if ($urandom_range(0, 3) != 0) r.address[12:10] = 3'b000;
            end
        end else begin
            r = t_req'(24'($urandom));
        end
        return r;
    endfunction

    task automatic test_directed_cases();
        idle_pct = 0;
        cpu_access(OP_WRITE, RGN_VIDEO, 14'h0000, 8'hff);
        cpu_access(OP_READ,  RGN_VIDEO, 14'h0000, 8'h00);
        set_regs(8'h00, 8'h20);
        cpu_access(OP_WRITE, RGN_VIDEO, 14'h0000, 8'ha5);
        cpu_access(OP_READ,  RGN_VIDEO, 14'h0000, 8'hff);
        cpu_access(OP_WRITE, RGN_VIDEO, 14'h1f20, 8'hff);
        cpu_access(OP_READ,  RGN_VIDEO, 14'h1f20, 8'h00);
        cpu_access(OP_WRITE, RGN_VIDEO, 14'h3fff, 8'hff);
        cpu_access(OP_READ,  RGN_VIDEO, 14'h3fff, 8'h00);
        cpu_access(OP_WRITE, RGN_COLOR, 14'h0000, 8'hff);
        cpu_access(OP_READ,  RGN_COLOR, 14'h0000, 8'h00);
        set_regs(8'hff, 8'hff);
        cpu_access(OP_WRITE, RGN_VIDEO, 14'h2040, 8'h01);
        cpu_access(OP_READ,  RGN_VIDEO, 14'h2040, 8'h00);
        cpu_access(OP_WRITE, RGN_VIDEO, 14'h1fe0, 8'h80);
        cpu_access(OP_READ,  RGN_VIDEO, 14'h1fe0, 8'h00);
        cpu_access(OP_WRITE, RGN_VIDEO, 14'h0000, 8'h3c);
        cpu_access(OP_WRITE, RGN_COLOR, 14'h3f1f, 8'h00);
        cpu_access(OP_READ,  RGN_COLOR, 14'h1e1f, 8'hff);
        cpu_access(OP_WRITE, RGN_COLOR, 14'h00e0, 8'hff);
        cpu_access(OP_READ,  RGN_COLOR, 14'h00e0, 8'h00);
        set_regs(8'h5a, 8'h40);
        cpu_access(OP_WRITE, RGN_COLOR, 14'h0203, 8'h5b);
        cpu_access(OP_READ,  RGN_COLOR, 14'h0303, 8'h00);
        cpu_access(OP_WRITE, RGN_VIDEO, 14'h0120, 8'hff);
        cpu_access(OP_READ,  RGN_COLOR, 14'h0120, 8'h00);
        cpu_access(OP_READ,  RGN_VIDEO, 14'h3fff, 8'h00);
    endtask

    task automatic test_random_phases();
        logic [7:0] shift_v, mode_v;
        for (int p = 0; p < PHASES; p++) begin
            shift_v      = 8'($urandom);
            mode_v       = 8'($urandom);
            mode_v[3:0]  = 4'(p);
            if ($urandom_range(0, 3) != 0) mode_v[5] = 1'b1;
            if (p == 0) begin
                shift_v = 8'hff;
                mode_v  = 8'hff;
            end
            if (p == 1) begin
                shift_v = 8'h00;
                mode_v  = 8'h00;
            end
            set_regs(shift_v, mode_v);
            idle_pct = (p % 4 == 3) ? 0 : $urandom_range(5, 40);
            make_hot_set();
            repeat (WORDS_PER_PHASE) send_access(rand_access());
        end
    endtask

    task automatic test_output_backpressure();
        set_regs(8'($urandom), 8'($urandom) | 8'h20);
        idle_pct = 0;
        make_hot_set();
        rsp_hold_cycles = LONG_HOLD;
        repeat (40) send_access(rand_access());
        wait_drain();
        idle_pct = 20;
        repeat (40) send_access(rand_access());
    endtask

    task automatic test_steady_stream();
        set_regs(8'($urandom), 8'($urandom) | 8'h20);
        idle_pct = 0;
        make_hot_set();
        repeat (60) send_access(rand_access());
    endtask

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        rsp_if.ready = 1'b0;
        foreach (bitmap_mem[k]) bitmap_mem[k] = '0;
        foreach (color_mem[k]) color_mem[k] = '0;
        pen_color = '0;
        shift_reg = '0;
        mode_reg  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_phases();
        test_output_backpressure();
        test_steady_stream();
        wait_drain();

        if (fail_count == 0 && rsp_due.size() == 0) begin
            $display("tb_bitplane_blit_alu_memory_core: clean");
        end else begin
            $display("tb_bitplane_blit_alu_memory_core: errors");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("tb_bitplane_blit_alu_memory_core: errors");
        $finish;
    end

endmodule
